/* design/ir_code_pulse_unpacker_macros.svh */
// Assertion macros for the IR code pulse unpacker.
// Depends on: nothing; users provide clk and rst in scope.
`ifndef IR_CODE_PULSE_UNPACKER_MACROS_SVH
`define IR_CODE_PULSE_UNPACKER_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define ICPU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ICPU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/icpu_pkg.sv */
// Shared types, field positions, codes and the microcode ROM of the IR code pulse unpacker.
// Depends on: nothing.
package icpu_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int BYTE_BITS         = 8;
  localparam int MAX_INDEX_BITS    = 6;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 6;
  localparam int TIME_W   = 16;
  localparam int CAR_W    = 8;
  localparam int PAIRS_W  = 8;
  localparam int IBITS_W  = 3;
  localparam int BYTE_W   = 8;
  localparam int BLEFT_W  = 4;

  // Request payload layout, lowest bit first
  localparam int IN_ENTRY_LSB = 0;
  localparam int IN_ON_LSB    = IN_ENTRY_LSB + IDX_W;
  localparam int IN_OFF_LSB   = IN_ON_LSB + TIME_W;
  localparam int IN_CAR_LSB   = IN_OFF_LSB + TIME_W;
  localparam int IN_PAIRS_LSB = IN_CAR_LSB + CAR_W;
  localparam int IN_IBITS_LSB = IN_PAIRS_LSB + PAIRS_W;
  localparam int IN_BYTE_LSB  = IN_IBITS_LSB + IBITS_W;
  localparam int IN_USED_W    = IN_BYTE_LSB + BYTE_W;
  localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Result payload layout
  localparam int OUT_USED_W  = 2 * TIME_W + 1 + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // Request kinds
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  // Microcode fields
  localparam int STEP_W  = 4;
  localparam int OP_W    = 4;
  localparam int STALL_W = 2;
  localparam int JUMP_W  = 3;

  localparam logic [STALL_W-1:0] STALL_NONE     = 2'd0;
  localparam logic [STALL_W-1:0] STALL_NO_INPUT = 2'd1;
  localparam logic [STALL_W-1:0] STALL_OUT_BUSY = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH  = 4'd1;
  localparam logic [OP_W-1:0] OP_BYTE   = 4'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 4'd3;
  localparam logic [OP_W-1:0] OP_START  = 4'd4;
  localparam logic [OP_W-1:0] OP_BIT    = 4'd5;
  localparam logic [OP_W-1:0] OP_LOOKUP = 4'd6;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd7;
  localparam logic [OP_W-1:0] OP_FINISH = 4'd8;

  localparam logic [JUMP_W-1:0] J_NEVER      = 3'd0;
  localparam logic [JUMP_W-1:0] J_ALWAYS     = 3'd1;
  localparam logic [JUMP_W-1:0] J_IS_LOAD    = 3'd2;
  localparam logic [JUMP_W-1:0] J_IS_START   = 3'd3;
  localparam logic [JUMP_W-1:0] J_SKIP_DATA  = 3'd4;
  localparam logic [JUMP_W-1:0] J_INDEX_PART = 3'd5;
  localparam logic [JUMP_W-1:0] J_MORE_BITS  = 3'd6;

  // Program steps
  localparam logic [STEP_W-1:0] S_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] S_DISP_LD  = 4'd1;
  localparam logic [STEP_W-1:0] S_DISP_ST  = 4'd2;
  localparam logic [STEP_W-1:0] S_DISP_DT  = 4'd3;
  localparam logic [STEP_W-1:0] S_BYTE     = 4'd4;
  localparam logic [STEP_W-1:0] S_WRITE    = 4'd5;
  localparam logic [STEP_W-1:0] S_START    = 4'd6;
  localparam logic [STEP_W-1:0] S_BIT      = 4'd7;
  localparam logic [STEP_W-1:0] S_CHECK    = 4'd8;
  localparam logic [STEP_W-1:0] S_LOOKUP   = 4'd9;
  localparam logic [STEP_W-1:0] S_EMIT     = 4'd10;
  localparam logic [STEP_W-1:0] S_LOOP     = 4'd11;
  localparam logic [STEP_W-1:0] S_FINISH   = 4'd12;

  typedef struct packed {
    logic [STALL_W-1:0] stall;   // hold in place, op suppressed
    logic [OP_W-1:0]    op;      // datapath action when not stalled
    logic [JUMP_W-1:0]  jump;    // jump condition
    logic [STEP_W-1:0]  target;  // jump destination
  } ctl_word_t;

  function automatic ctl_word_t ucode(input logic [STEP_W-1:0] step);
    ctl_word_t cw;
    cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_ALWAYS, target: S_FETCH};
    unique case (step)
      S_FETCH:   cw = '{stall: STALL_NO_INPUT, op: OP_LATCH, jump: J_NEVER,
                        target: S_FETCH};
      S_DISP_LD: cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_IS_LOAD, target: S_WRITE};
      S_DISP_ST: cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_IS_START, target: S_START};
      S_DISP_DT: cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_SKIP_DATA, target: S_FETCH};
      S_BYTE:    cw = '{stall: STALL_NONE, op: OP_BYTE, jump: J_ALWAYS, target: S_BIT};
      S_WRITE:   cw = '{stall: STALL_NONE, op: OP_WRITE, jump: J_ALWAYS, target: S_FETCH};
      S_START:   cw = '{stall: STALL_NONE, op: OP_START, jump: J_ALWAYS, target: S_FETCH};
      S_BIT:     cw = '{stall: STALL_NONE, op: OP_BIT, jump: J_NEVER, target: S_FETCH};
      S_CHECK:   cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_INDEX_PART, target: S_LOOP};
      S_LOOKUP:  cw = '{stall: STALL_NONE, op: OP_LOOKUP, jump: J_NEVER, target: S_FETCH};
      S_EMIT:    cw = '{stall: STALL_OUT_BUSY, op: OP_EMIT, jump: J_NEVER, target: S_FETCH};
      S_LOOP:    cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_MORE_BITS, target: S_BIT};
      S_FINISH:  cw = '{stall: STALL_NONE, op: OP_FINISH, jump: J_ALWAYS, target: S_FETCH};
      default:   cw = '{stall: STALL_NONE, op: OP_NOP, jump: J_ALWAYS, target: S_FETCH};
    endcase
    return cw;
  endfunction

endpackage

/* design/icpu_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on: nothing.
module icpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ir_code_pulse_unpacker.sv */
// Top level of the IR code pulse unpacker: microcoded sequencer, bit datapath, output register.
// Depends on: icpu_pkg, icpu_ram, ir_code_pulse_unpacker_macros.svh.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser = cmd, tdata = load/start/byte fields
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata = pulse pair, tlast = last_pair
//
// A request is taken only in the fetch step of the program. Load: fetch, load dispatch, write.
// Start: fetch, load and start dispatch, start. Dropped byte or unused command: fetch, then load,
// start and data dispatch. Data byte: fetch and the dispatch steps, then the byte step fills the buffer;
// each bit walked takes bit, check and loop, an emitted pair adds lookup and emit, and finish closes.
// Reset is synchronous, clears control state and the output valid; the table is not cleared.
// A full output register stalls the sequencer in the emit step; requests wait in fetch.
`include "ir_code_pulse_unpacker_macros.svh"

module ir_code_pulse_unpacker #(
  parameter int TABLE_ENTRIES = icpu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_index, mark_time, space_time, carrier_divisor, pair_count, index_bits, data_byte, pad
  input  logic [icpu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd
  input  logic [icpu_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pulse mark time, pulse space time, use_carrier, table_index, pad
  output logic [icpu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  // Sequencer
  logic [icpu_pkg::STEP_W-1:0] step, step_next;
  icpu_pkg::ctl_word_t         cw;
  logic                        stall, take, fire;

  // Control state
  logic [icpu_pkg::BYTE_W-1:0]  bit_buffer;
  logic [icpu_pkg::BLEFT_W-1:0] bits_left;
  logic [icpu_pkg::IDX_W-1:0]   partial_index;
  logic [icpu_pkg::IBITS_W-1:0] partial_count;
  logic [icpu_pkg::PAIRS_W-1:0] pairs_remaining;
  logic [icpu_pkg::IBITS_W-1:0] width_in_use;
  logic [icpu_pkg::CAR_W-1:0]   carrier_in_use;

  // Latched request
  logic [icpu_pkg::CMD_W-1:0]     item_cmd;
  logic [icpu_pkg::IN_USED_W-1:0] item;

  logic [icpu_pkg::IDX_W-1:0]   it_entry;
  logic [icpu_pkg::TIME_W-1:0]  it_on, it_off;
  logic [icpu_pkg::CAR_W-1:0]   it_car;
  logic [icpu_pkg::PAIRS_W-1:0] it_pairs;
  logic [icpu_pkg::IBITS_W-1:0] it_ibits, ibits_sat;
  logic [icpu_pkg::BYTE_W-1:0]  it_byte;

  // Lookup and output
  logic [icpu_pkg::IDX_W-1:0]    look_index;
  logic                          look_hit, look_last;
  logic [2*icpu_pkg::TIME_W-1:0] ram_rdata;
  logic                          ram_we, ram_re;
  logic [icpu_pkg::TIME_W-1:0]   out_on, out_off;
  logic                          out_carrier;
  logic [icpu_pkg::IDX_W-1:0]    out_index;
  logic                          out_last;
  logic                          out_valid;

  logic [icpu_pkg::BLEFT_W-1:0] bits_left_dec;
  logic                         next_bit;
  logic                         entry_in_range, index_in_range;

  // Check terms
  logic                         width_ok, in_lookup, in_bit;

  assign it_entry = item[icpu_pkg::IN_ENTRY_LSB +: icpu_pkg::IDX_W];
  assign it_on    = item[icpu_pkg::IN_ON_LSB    +: icpu_pkg::TIME_W];
  assign it_off   = item[icpu_pkg::IN_OFF_LSB   +: icpu_pkg::TIME_W];
  assign it_car   = item[icpu_pkg::IN_CAR_LSB   +: icpu_pkg::CAR_W];
  assign it_pairs = item[icpu_pkg::IN_PAIRS_LSB +: icpu_pkg::PAIRS_W];
  assign it_ibits = item[icpu_pkg::IN_IBITS_LSB +: icpu_pkg::IBITS_W];
  assign it_byte  = item[icpu_pkg::IN_BYTE_LSB  +: icpu_pkg::BYTE_W];

  // Index width saturates to 1..6
  always_comb begin
    if (it_ibits == '0) begin
      ibits_sat = icpu_pkg::IBITS_W'(1);
    end else if (it_ibits > icpu_pkg::IBITS_W'(icpu_pkg::MAX_INDEX_BITS)) begin
      ibits_sat = icpu_pkg::IBITS_W'(icpu_pkg::MAX_INDEX_BITS);
    end else begin
      ibits_sat = it_ibits;
    end
  end

  assign cw = icpu_pkg::ucode(step);

  always_comb begin
    unique case (cw.stall)
      icpu_pkg::STALL_NONE:     stall = 1'b0;
      icpu_pkg::STALL_NO_INPUT: stall = !s_axis_tvalid;
      icpu_pkg::STALL_OUT_BUSY: stall = out_valid && !m_axis_tready;
      default:                  stall = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cw.jump)
      icpu_pkg::J_NEVER:      take = 1'b0;
      icpu_pkg::J_ALWAYS:     take = 1'b1;
      icpu_pkg::J_IS_LOAD:    take = (item_cmd == icpu_pkg::CMD_LOAD);
      icpu_pkg::J_IS_START:   take = (item_cmd == icpu_pkg::CMD_START);
      icpu_pkg::J_SKIP_DATA:  take = (item_cmd != icpu_pkg::CMD_DATA) ||
                                     (pairs_remaining == '0);
      icpu_pkg::J_INDEX_PART: take = (partial_count < width_in_use);
      icpu_pkg::J_MORE_BITS:  take = (bits_left != '0) && (pairs_remaining != '0);
      default:                take = 1'b0;
    endcase
  end

  assign fire = !stall;

  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (take) begin
      step_next = cw.target;
    end else begin
      step_next = step + icpu_pkg::STEP_W'(1);
    end
  end

  assign s_axis_tready = (cw.stall == icpu_pkg::STALL_NO_INPUT);

  // Bit datapath: MSB first out of the buffer
  assign bits_left_dec = bits_left - icpu_pkg::BLEFT_W'(1);
  assign next_bit      = bit_buffer[bits_left_dec[2:0]];

  assign entry_in_range = ({1'b0, it_entry} < (icpu_pkg::IDX_W + 1)'(TABLE_ENTRIES));
  assign index_in_range = ({1'b0, partial_index} < (icpu_pkg::IDX_W + 1)'(TABLE_ENTRIES));

  assign ram_we = fire && (cw.op == icpu_pkg::OP_WRITE) && entry_in_range;
  assign ram_re = fire && (cw.op == icpu_pkg::OP_LOOKUP);

  icpu_ram #(
    .WIDTH (2 * icpu_pkg::TIME_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (it_entry[AW-1:0]),
    .wdata ({it_off, it_on}),
    .re    (ram_re),
    .raddr (partial_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step            <= icpu_pkg::S_FETCH;
      bit_buffer      <= '0;
      bits_left       <= '0;
      partial_index   <= '0;
      partial_count   <= '0;
      pairs_remaining <= '0;
      width_in_use    <= icpu_pkg::IBITS_W'(1);
      carrier_in_use  <= '0;
    end else begin
      step <= step_next;
      if (fire) begin
        case (cw.op)
          icpu_pkg::OP_BYTE: begin
            bit_buffer <= it_byte;
            bits_left  <= icpu_pkg::BLEFT_W'(icpu_pkg::BYTE_BITS);
          end
          icpu_pkg::OP_START: begin
            carrier_in_use  <= it_car;
            pairs_remaining <= it_pairs;
            width_in_use    <= ibits_sat;
            bit_buffer      <= '0;
            bits_left       <= '0;
            partial_index   <= '0;
            partial_count   <= '0;
          end
          icpu_pkg::OP_BIT: begin
            bits_left     <= bits_left_dec;
            partial_index <= {partial_index[icpu_pkg::IDX_W-2:0], next_bit};
            partial_count <= partial_count + icpu_pkg::IBITS_W'(1);
          end
          icpu_pkg::OP_LOOKUP: begin
            pairs_remaining <= pairs_remaining - icpu_pkg::PAIRS_W'(1);
            partial_index   <= '0;
            partial_count   <= '0;
          end
          icpu_pkg::OP_FINISH: begin
            if (pairs_remaining == '0) begin
              bits_left     <= '0;
              partial_index <= '0;
              partial_count <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output valid: set by the emit step, dropped once the pair is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (cw.op == icpu_pkg::OP_EMIT)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (fire) begin
      case (cw.op)
        icpu_pkg::OP_LATCH: begin
          item_cmd <= s_axis_tuser;
          item     <= s_axis_tdata[icpu_pkg::IN_USED_W-1:0];
        end
        icpu_pkg::OP_LOOKUP: begin
          look_index <= partial_index;
          look_hit   <= index_in_range;
          look_last  <= (pairs_remaining == icpu_pkg::PAIRS_W'(1));
        end
        icpu_pkg::OP_EMIT: begin
          out_on      <= look_hit ? ram_rdata[icpu_pkg::TIME_W-1:0] : '0;
          out_off     <= look_hit ? ram_rdata[2*icpu_pkg::TIME_W-1:icpu_pkg::TIME_W] : '0;
          out_carrier <= (carrier_in_use != '0);
          out_index   <= look_index;
          out_last    <= look_last;
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {{icpu_pkg::OUT_PAD_W{1'b0}}, out_index, out_carrier, out_off, out_on};

  // Checks
  assign width_ok  = (width_in_use != '0) &&
                     (width_in_use <= icpu_pkg::IBITS_W'(icpu_pkg::MAX_INDEX_BITS));
  assign in_lookup = (step == icpu_pkg::S_LOOKUP);
  assign in_bit    = (step == icpu_pkg::S_BIT);

  `ICPU_ASSERT_ALWAYS(a_width_range, width_ok, "index width out of range")
  `ICPU_ASSERT_ALWAYS(a_partial_bound, partial_count <= width_in_use, "partial index overran")
  `ICPU_ASSERT_IMPLIES(a_lookup_pairs, in_lookup, pairs_remaining != '0, "lookup past end")
  `ICPU_ASSERT_IMPLIES(a_bit_avail, in_bit, bits_left != '0, "bit step with empty buffer")

endmodule
